// ----- sv/hkrd_pkg.sv -----
// shared types and constants for the keyboard report differ
package hkrd_pkg;

    // report and event layout
    localparam int SLOT_W       = 8;
    localparam int MAX_SLOTS    = 6;
    localparam int MOD_COUNT    = 6;
    localparam int KEY_SLOTS_DEF = 6;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 8;
    localparam int OUT_USER_W   = 2;

    // tuser bit positions on the event side
    localparam int USER_RELEASE  = 0;
    localparam int USER_MODIFIER = 1;

    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [MOD_COUNT-1:0] mods_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic compute;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pending;
    } dp_status_t;

endpackage

// ----- sv/hkrd_ctrl.sv -----
// controller: sequences capture, difference and drain of one report
module hkrd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  hkrd_pkg::dp_status_t status,
    output hkrd_pkg::dp_cmd_t    cmd
);
    import hkrd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!status.pending)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands
    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.capture = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.compute = (state_reg == ST_CALC);

endmodule

// ----- sv/hkrd_dp.sv -----
// datapath: report registers, event masks and the event output register
module hkrd_dp
#(
    parameter int KEY_SLOTS = hkrd_pkg::KEY_SLOTS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hkrd_pkg::dp_cmd_t    cmd,
    output hkrd_pkg::dp_status_t status,
    input  hkrd_pkg::slot_t      slot_in [hkrd_pkg::MAX_SLOTS],
    input  hkrd_pkg::mods_t      mods_in,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 out_release,
    output logic                 out_modifier,
    output hkrd_pkg::slot_t      out_code,
    output logic                 out_last
);
    import hkrd_pkg::*;

    slot_t cur_slots_reg [KEY_SLOTS];
    slot_t prev_slots_reg [KEY_SLOTS];
    slot_t rel_slots_reg [KEY_SLOTS];
    mods_t cur_mods_reg;
    mods_t prev_mods_reg;

    logic [KEY_SLOTS-1:0] press_mask_reg;
    logic [KEY_SLOTS-1:0] rel_mask_reg;
    mods_t                mod_mask_reg;

    logic [KEY_SLOTS-1:0] press_mask_next;
    logic [KEY_SLOTS-1:0] rel_mask_next;

    logic [KEY_SLOTS-1:0] press_pick;
    logic [KEY_SLOTS-1:0] rel_pick;
    mods_t                mod_pick;
    logic                 pick_release;
    logic                 pick_modifier;
    slot_t                pick_code;
    logic                 pick_last;
    logic                 any_pending;
    logic                 load_out;

    logic  out_valid_reg;
    logic  out_release_reg;
    logic  out_modifier_reg;
    slot_t out_code_reg;
    logic  out_last_reg;

    // capture the incoming report
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                cur_slots_reg[i] <= slot_in[i];
            end
            cur_mods_reg <= mods_in;
        end
    end

    // press and release candidates, scans stop at the first empty slot
    always_comb
    begin
        logic run_cur;
        logic run_prev;
        logic hit_cur;
        logic hit_prev;
        run_cur  = 1'b1;
        run_prev = 1'b1;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            run_cur  = run_cur && (cur_slots_reg[i] != '0);
            run_prev = run_prev && (prev_slots_reg[i] != '0);
            hit_cur  = 1'b0;
            hit_prev = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                hit_cur  = hit_cur || (cur_slots_reg[i] == prev_slots_reg[j]);
                hit_prev = hit_prev || (prev_slots_reg[i] == cur_slots_reg[j]);
            end
            press_mask_next[i] = run_cur && !hit_cur;
            rel_mask_next[i]   = run_prev && !hit_prev;
        end
    end

    // lowest pending event wins: presses, then releases, then modifiers
    always_comb
    begin
        logic found;
        found         = 1'b0;
        press_pick    = '0;
        rel_pick      = '0;
        mod_pick      = '0;
        pick_release  = 1'b0;
        pick_modifier = 1'b0;
        pick_code     = '0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (press_mask_reg[i] && !found)
            begin
                found         = 1'b1;
                press_pick[i] = 1'b1;
                pick_code     = cur_slots_reg[i];
            end
        end
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (rel_mask_reg[i] && !found)
            begin
                found        = 1'b1;
                rel_pick[i]  = 1'b1;
                pick_release = 1'b1;
                pick_code    = rel_slots_reg[i];
            end
        end
        for (int i = 0; i < MOD_COUNT; i++)
        begin
            if (mod_mask_reg[i] && !found)
            begin
                found         = 1'b1;
                mod_pick[i]   = 1'b1;
                pick_modifier = 1'b1;
                pick_release  = !cur_mods_reg[i];
                pick_code     = SLOT_W'(i);
            end
        end
    end

    assign any_pending = (|press_mask_reg) || (|rel_mask_reg) || (|mod_mask_reg);
    assign pick_last   = !((|(press_mask_reg & ~press_pick)) || (|(rel_mask_reg & ~rel_pick))
                           || (|(mod_mask_reg & ~mod_pick)));
    assign load_out    = any_pending && (!out_valid_reg || out_ready);

    // previous report and pending event masks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_slots_reg[i] <= '0;
            end
            prev_mods_reg  <= '0;
            press_mask_reg <= '0;
            rel_mask_reg   <= '0;
            mod_mask_reg   <= '0;
        end
        else if (cmd.compute)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                prev_slots_reg[i] <= cur_slots_reg[i];
            end
            prev_mods_reg  <= cur_mods_reg;
            press_mask_reg <= press_mask_next;
            rel_mask_reg   <= rel_mask_next;
            mod_mask_reg   <= cur_mods_reg ^ prev_mods_reg;
        end
        else if (load_out)
        begin
            press_mask_reg <= press_mask_reg & ~press_pick;
            rel_mask_reg   <= rel_mask_reg & ~rel_pick;
            mod_mask_reg   <= mod_mask_reg & ~mod_pick;
        end
    end

    // release codes come from the report being replaced
    always_ff @(posedge clk)
    begin
        if (cmd.compute)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                rel_slots_reg[i] <= prev_slots_reg[i];
            end
        end
    end

    // event output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_release_reg  <= pick_release;
            out_modifier_reg <= pick_modifier;
            out_code_reg     <= pick_code;
            out_last_reg     <= pick_last;
        end
    end

    assign status.pending = any_pending;
    assign out_valid      = out_valid_reg;
    assign out_release    = out_release_reg;
    assign out_modifier   = out_modifier_reg;
    assign out_code       = out_code_reg;
    assign out_last       = out_last_reg;

endmodule

// ----- sv/hid_key_report_diff.sv -----
// top level of the keyboard report differ
//
// Input channel (s_*): one beat carries a keyboard report, six key usage
// code slots and six modifier bits. Output channel (m_*): one beat per key
// event; tdata is the key code or modifier index, tuser says release and
// modifier, tlast marks the final event of a report. A report with no change
// gives no beats.
// Events come in order: presses in slot order, releases in previous-slot
// order, then modifier edges lctrl, lshift, lalt, rctrl, rshift, ralt.
// The report beat goes into the report registers, the calc state sets the
// event masks, and the first event then loads into the output register.
// A report gives 0 to 18 events; unless the receiver stalls, one event
// leaves per cycle from the output register, set by the single event picker.
// The next report is taken while the last event of the previous one still
// waits in the output register.
// A stalled receiver holds the output beat and the drain of further events.
// Reset clears the stored previous report to all empty slots and no
// modifiers, and drops any pending events.
module hid_key_report_diff
#(
    parameter int KEY_SLOTS = hkrd_pkg::KEY_SLOTS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // slot_0 .. slot_5 (8 bits each), modifier_bits (6), 2 zero bits
    input  logic [hkrd_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // event_code (8)
    output logic [hkrd_pkg::OUT_DATA_W-1:0]   m_tdata,
    // is_release (1), is_modifier (1)
    output logic [hkrd_pkg::OUT_USER_W-1:0]   m_tuser,
    output logic                              m_tlast
);
    import hkrd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    slot_t      slot_in [MAX_SLOTS];
    mods_t      mods_in;
    logic       ev_release;
    logic       ev_modifier;

    // unpack the report beat
    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            slot_in[i] = s_tdata[i*SLOT_W +: SLOT_W];
        end
        mods_in = s_tdata[MAX_SLOTS*SLOT_W +: MOD_COUNT];
    end

    hkrd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hkrd_dp #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .slot_in      (slot_in),
        .mods_in      (mods_in),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_release  (ev_release),
        .out_modifier (ev_modifier),
        .out_code     (m_tdata),
        .out_last     (m_tlast)
    );

    // pack the event flags
    always_comb
    begin
        m_tuser                = '0;
        m_tuser[USER_RELEASE]  = ev_release;
        m_tuser[USER_MODIFIER] = ev_modifier;
    end

endmodule
